/* sv/dwq_pkg.sv */
// Shared types and constants for the deduplicating worklist.
// No dependencies; used by dwq_mark and dedup_worklist_queue_stack.
`default_nettype none

package dwq_pkg;

  localparam int VERTICES_DEF = 1024;
  localparam int VERTEX_W     = 10;

  localparam logic ACT_OFFER = 1'b0;
  localparam logic ACT_TAKE  = 1'b1;

  typedef struct packed {
    logic en;
    logic val;
  } mark_wr_t;

endpackage

`default_nettype wire

/* sv/dwq_mark.sv */
// Membership bitmap: one-bit synchronous memory, one read and one write port.
// Runs a clearing sweep after reset. Depends on dwq_pkg.
`default_nettype none

module dwq_mark #(
  parameter int DEPTH = dwq_pkg::VERTICES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic                   rd_data,
  input  wire dwq_pkg::mark_wr_t wr,
  input  wire logic [AW-1:0]     wr_addr,
  output logic                   ready
);

  logic          mark_mem [DEPTH];
  logic [AW-1:0] clr_r;
  logic          busy_r;
  logic          rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (clr_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
      clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mark_mem[clr_r] <= 1'b0;
    end else if (wr.en) begin
      mark_mem[wr_addr] <= wr.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mark_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !busy_r;

endmodule

`default_nettype wire

/* sv/dedup_worklist_queue_stack.sv */
// Top level of the deduplicating worklist: ring store, pointers, control.
// Depends on dwq_pkg and dwq_mark.
//
// The accept edge of a request reads the membership bitmap and the ring store,
// the next edge writes both back and loads the result register. A new request
// can be taken in the cycle after that, at the same edge that takes the result;
// a result that is not taken holds in_tready low. No request is taken while
// the last one executes, as both memories have registered reads. After reset
// the bitmap is cleared one entry per cycle, with in_tready low.
`default_nettype none

module dedup_worklist_queue_stack #(
  parameter int VERTICES = dwq_pkg::VERTICES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // vertex[9:0], vertex_is_top[10], zero pad
  input  wire logic        in_tuser,   // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // accepted[0], taken_valid[1],
                                       // taken_vertex[11:2], is_empty[12], pad
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data // stack_mode
);

  localparam int VW = dwq_pkg::VERTEX_W;
  localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int IW = (AW > VW) ? AW : VW;
  localparam int CW = AW + 1;
  localparam int RW = (IW >= CW) ? IW : CW;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic          state_r, state_nxt;
  logic          stack_mode_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          act_r;
  logic [VW-1:0] vtx_r;
  logic          top_r;

  logic          out_valid_r;
  logic          o_acc_r, o_tv_r, o_empty_r;
  logic [VW-1:0] o_vtx_r;

  logic [VW-1:0] ring_mem [VERTICES];
  logic [VW-1:0] ring_rd_r;
  logic          ring_we;
  logic [AW-1:0] ring_rd_addr;

  logic          mark_rd;
  logic          mark_ready;
  dwq_pkg::mark_wr_t mark_wr;
  logic [AW-1:0] mark_wr_addr;
  logic [AW-1:0] in_vidx;

  logic          in_fire;
  logic [AW-1:0] tail_inc, tail_dec, head_inc;
  logic [IW-1:0] vtx_ext, res_ext, in_ext;
  logic          vtx_in_range, res_in_range;
  logic          offer_ok, nonempty;
  logic          acc_nxt, tv_nxt;
  logic [VW-1:0] res_vtx;

  assign in_tready = (state_r == ST_IDLE) && mark_ready && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign tail_inc = (tail_r == AW'(VERTICES - 1)) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? AW'(VERTICES - 1) : tail_r - 1'b1;
  assign head_inc = (head_r == AW'(VERTICES - 1)) ? '0 : head_r + 1'b1;

  assign in_ext       = IW'(in_tdata[VW-1:0]);
  assign in_vidx      = in_ext[AW-1:0];
  assign ring_rd_addr = stack_mode_r ? tail_dec : head_r;

  assign vtx_ext      = IW'(vtx_r);
  assign res_ext      = IW'(ring_rd_r);
  assign vtx_in_range = (RW'(vtx_ext) < RW'(VERTICES));
  assign res_in_range = (RW'(res_ext) < RW'(VERTICES));
  assign nonempty     = (cnt_r != '0);
  assign offer_ok     = vtx_in_range && !top_r && !mark_rd && (cnt_r != CW'(VERTICES));

  dwq_mark #(
    .DEPTH (VERTICES),
    .AW    (AW)
  ) u_mark (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_vidx),
    .rd_data (mark_rd),
    .wr      (mark_wr),
    .wr_addr (mark_wr_addr),
    .ready   (mark_ready)
  );

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    cnt_nxt      = cnt_r;
    mark_wr      = '0;
    mark_wr_addr = vtx_ext[AW-1:0];
    ring_we      = 1'b0;
    acc_nxt      = 1'b0;
    tv_nxt       = 1'b0;
    res_vtx      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        if (act_r == dwq_pkg::ACT_OFFER) begin
          if (offer_ok) begin
            mark_wr  = '{en: 1'b1, val: 1'b1};
            ring_we  = 1'b1;
            tail_nxt = tail_inc;
            cnt_nxt  = cnt_r + 1'b1;
            acc_nxt  = 1'b1;
          end
        end else if (nonempty) begin
          res_vtx      = ring_rd_r;
          tv_nxt       = 1'b1;
          cnt_nxt      = cnt_r - 1'b1;
          mark_wr_addr = res_ext[AW-1:0];
          mark_wr      = '{en: res_in_range, val: 1'b0};
          if (stack_mode_r) begin
            tail_nxt = tail_dec;
          end else begin
            head_nxt = head_inc;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[tail_r] <= vtx_r;
    end
    if (in_fire) begin
      ring_rd_r <= ring_mem[ring_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= in_tuser;
      vtx_r <= in_tdata[VW-1:0];
      top_r <= in_tdata[VW];
    end
    if (state_r == ST_EXEC) begin
      o_acc_r   <= acc_nxt;
      o_tv_r    <= tv_nxt;
      o_vtx_r   <= res_vtx;
      o_empty_r <= (cnt_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      stack_mode_r <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        stack_mode_r <= cfg_wr_data;
      end
      if (state_r == ST_EXEC) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, o_empty_r, o_vtx_r, o_tv_r, o_acc_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(VERTICES))
    else $error("entry count above store depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == tail_r))
    else $error("empty worklist with head and tail apart");

  a_fire_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted request did not enter execute");

  a_rose_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result appeared without an executed request");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(o_acc_r && o_tv_r))
    else $error("result both accepted an offer and returned a vertex");

endmodule

`default_nettype wire

/* bench/tb_dedup_worklist_queue_stack.sv */
// Self-checking bench for dedup_worklist_queue_stack: directed and random offer/take
// requests, both modes, and a per-request prediction of the result stream.
// Depends on dwq_pkg and the RTL of the worklist.
`default_nettype none

module tb_dedup_worklist_queue_stack;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit MODE_QUEUE = 1'b0;
  localparam bit MODE_STACK = 1'b1;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic                         accepted;
    logic                         taken_valid;
    logic [dwq_pkg::VERTEX_W-1:0] taken_vertex;
    logic                         is_empty;
  } wl_result_t;

  class worklist_tracker;
    logic [dwq_pkg::VERTEX_W-1:0] ring [dwq_pkg::VERTICES_DEF];
    bit                           queued [dwq_pkg::VERTICES_DEF];
    logic [dwq_pkg::VERTEX_W-1:0] head;
    logic [dwq_pkg::VERTEX_W-1:0] tail;
    int unsigned                  count;
    bit                           stack_mode;
    wl_result_t                   due_results [$];
    int                           errors;

    function new();
      head = '0;
      tail = '0;
      count = 0;
      stack_mode = MODE_QUEUE;
      errors = 0;
      foreach (queued[i]) queued[i] = 1'b0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void log_request(logic act, logic [dwq_pkg::VERTEX_W-1:0] v, logic top);
      wl_result_t r;
      r = '0;
      if (act == dwq_pkg::ACT_OFFER) begin
        if (!top && !queued[v] && count < dwq_pkg::VERTICES_DEF) begin
          queued[v] = 1'b1;
          ring[tail] = v;
          tail++;
          count++;
          r.accepted = 1'b1;
        end
      end else if (count != 0) begin
        if (stack_mode == MODE_STACK) begin
          tail--;
          r.taken_vertex = ring[tail];
        end else begin
          r.taken_vertex = ring[head];
          head++;
        end
        count--;
        queued[r.taken_vertex] = 1'b0;
        r.taken_valid = 1'b1;
      end
      r.is_empty = (count == 0);
      due_results.push_back(r);
    endfunction

    task match_result(logic [15:0] data);
      wl_result_t got;
      wl_result_t want;
      got.accepted = data[0];
      got.taken_valid = data[1];
      got.taken_vertex = data[11:2];
      got.is_empty = data[12];
      if (due_results.size() == 0) begin
        report($sformatf("result 0x%h with no request pending", data));
      end else begin
        want = due_results.pop_front();
        if (got.accepted !== want.accepted)
          report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
        if (got.taken_valid !== want.taken_valid)
          report($sformatf("taken_valid %b, want %b", got.taken_valid, want.taken_valid));
        if (got.taken_vertex !== want.taken_vertex)
          report($sformatf("taken_vertex %0d, want %0d", got.taken_vertex,
                           want.taken_vertex));
        if (got.is_empty !== want.is_empty)
          report($sformatf("is_empty %b, want %b", got.is_empty, want.is_empty));
      end
    endtask

    task flag_leftovers();
      if (due_results.size() != 0)
        report($sformatf("%0d results never arrived", due_results.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // vertex[9:0], vertex_is_top[10], zero pad
  logic        in_tuser = 1'b0; // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // accepted[0], taken_valid[1], taken_vertex[11:2],
                                // is_empty[12], pad
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;

  int unsigned idle_in_pct = 31;
  int unsigned stall_out_pct = 84;
  int unsigned cycles = 0;
  worklist_tracker tracker = new();

  dedup_worklist_queue_stack uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      tracker.match_result(out_tdata);
    out_tready <= ($urandom_range(99) >= stall_out_pct);
  end

  task automatic send_request(logic act, logic [dwq_pkg::VERTEX_W-1:0] v, logic top);
    while ($urandom_range(99) < idle_in_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {5'b0, top, v};
    do @(posedge clk); while (in_tready !== 1'b1);
    tracker.log_request(act, v, top);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.stack_mode = m;
  endtask

  task automatic offer(logic [dwq_pkg::VERTEX_W-1:0] v, logic top = 1'b0);
    send_request(dwq_pkg::ACT_OFFER, v, top);
  endtask

  task automatic take();
    send_request(dwq_pkg::ACT_TAKE, dwq_pkg::VERTEX_W'($urandom_range(1023)),
                 1'($urandom_range(1)));
  endtask

  task automatic run_segment(int n, int offer_pct, int pool_hi);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < offer_pct)
        offer(dwq_pkg::VERTEX_W'($urandom_range(pool_hi)), ($urandom_range(99) < 12));
      else
        take();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    set_mode(MODE_QUEUE);
    offer(10'd0);
    offer(10'd1023);
    offer(10'd1023);          // duplicate while queued
    offer(10'd512, 1'b1);     // top measure, never queued
    offer(10'h2AA);
    offer(10'h155);
    send_request(dwq_pkg::ACT_TAKE, 10'h3FF, 1'b1);
    offer(10'd0);             // re-offer after removal
    take();
    take();
    take();
    take();
    take();                   // empty worklist

    set_mode(MODE_STACK);
    offer(10'd7);
    offer(10'd8);
    offer(10'd9);
    take();
    offer(10'd9);
    set_mode(MODE_QUEUE);     // mode flip with entries held
    take();
    take();
    take();
    take();

    for (int p = 0; p < 6; p++) begin
      set_mode((p % 2 == 0) ? MODE_STACK : MODE_QUEUE);
      case (p / 2)
        0: begin
          idle_in_pct = 31;
          stall_out_pct = 84;
        end
        1: begin
          idle_in_pct = 84;
          stall_out_pct = 31;
        end
        default: begin
          idle_in_pct = 0;
          stall_out_pct = 0;
        end
      endcase
      run_segment(120, 90, 1023);
      run_segment(100, 55, 255);
      run_segment(60, 20, 1023);
    end

    drain_results();
    repeat (20) @(posedge clk);
    tracker.flag_leftovers();
    if (tracker.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
sv/dwq_pkg.sv
sv/dwq_mark.sv
sv/dedup_worklist_queue_stack.sv
bench/tb_dedup_worklist_queue_stack.sv
